// ===== rtl/block_map_deque_assert.svh =====
// assertion macros for the block map deque checker
// expects clk and arst_n in the scope where a macro is used
`ifndef BLOCK_MAP_DEQUE_ASSERT_SVH
`define BLOCK_MAP_DEQUE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define BMD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define BMD_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/bmd_pkg.sv =====
// shared constants, codes, structs and data conversion functions
// for the block map deque; no dependencies
`default_nettype none

package bmd_pkg;

	localparam int MAP_BLOCKS  = 8;
	localparam int BLOCK_SIZE  = 8;
	localparam int DATA_WIDTH  = 32;

	localparam int STORE_DEPTH = MAP_BLOCKS * BLOCK_SIZE;
	localparam int POS_W       = $clog2(STORE_DEPTH);
	localparam int OFF_W       = $clog2(BLOCK_SIZE);
	localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
	localparam int HOME_BASE   = (MAP_BLOCKS / 2) * BLOCK_SIZE;
	localparam int MID_OFF     = BLOCK_SIZE / 2;
	localparam int HOME_POS    = HOME_BASE + MID_OFF;

	localparam int FUNC_W      = 3;
	localparam int VALUE_W     = 32;
	localparam int INDEX_W     = 6;
	localparam int READ_W      = 32;
	localparam int STATUS_W    = 3;
	localparam int COUNT_W     = 7;

	typedef enum logic [FUNC_W-1:0] {
		FN_PUSH_BACK  = 3'd0,
		FN_PUSH_FRONT = 3'd1,
		FN_POP_BACK   = 3'd2,
		FN_POP_FRONT  = 3'd3,
		FN_READ       = 3'd4,
		FN_WRITE      = 3'd5
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 3'd0,
		ST_FULL_BACK  = 3'd1,
		ST_FULL_FRONT = 3'd2,
		ST_EMPTY      = 3'd3,
		ST_RANGE      = 3'd4
	} status_t;

	typedef struct packed {
		logic                  we;
		logic                  re;
		logic [POS_W-1:0]      addr;
		logic [DATA_WIDTH-1:0] wdata;
	} mem_cmd_t;

	typedef struct packed {
		logic               is_read;
		status_t            status;
		logic [COUNT_W-1:0] count;
	} rsp_ctl_t;

	function automatic logic [DATA_WIDTH-1:0] to_store(input logic signed [VALUE_W-1:0] v);
		logic signed [63:0] e;
		e = 64'(v);
		return e[DATA_WIDTH-1:0];
	endfunction

	function automatic logic [READ_W-1:0] from_store(input logic signed [DATA_WIDTH-1:0] d);
		logic signed [63:0] e;
		e = 64'(d);
		return e[READ_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/bmd_req_if.sv =====
// request channel of the block map deque: valid, ready and request fields
// depends on bmd_pkg
`default_nettype none

interface bmd_req_if;
	logic                                valid;
	logic                                ready;
	logic [bmd_pkg::FUNC_W-1:0]          func;
	logic signed [bmd_pkg::VALUE_W-1:0]  value;
	logic [bmd_pkg::INDEX_W-1:0]         index;

	modport source (output valid, func, value, index, input ready);
	modport sink (input valid, func, value, index, output ready);
endinterface

`default_nettype wire

// ===== rtl/bmd_rsp_if.sv =====
// result channel of the block map deque: valid, ready and result fields
// depends on bmd_pkg
`default_nettype none

interface bmd_rsp_if;
	logic                                valid;
	logic                                ready;
	logic signed [bmd_pkg::READ_W-1:0]   read_data;
	logic [bmd_pkg::STATUS_W-1:0]        status;
	logic [bmd_pkg::COUNT_W-1:0]         count;

	modport source (output valid, read_data, status, count, input ready);
	modport sink (input valid, read_data, status, count, output ready);
endinterface

`default_nettype wire

// ===== rtl/block_map_deque.sv =====
// Double-ended queue held in a 64-entry store without wrap-around. Every request
// (push or pop at either end, read or write at a logical index) gives exactly one
// result carrying read data, a status code and the element count after it.
// A request can be taken every cycle while results are taken; its result passes
// through the registered store read, then the output register, loaded once that is
// empty or its result is taken. Two requests may be in flight while a result
// waits. The element store needs no clearing after reset; only written slots are
// ever read.
// Depends on bmd_pkg, bmd_req_if, bmd_rsp_if, bmd_ram, bmd_ctrl and bmd_out.
`default_nettype none

module block_map_deque (
	input  wire logic clk,
	input  wire logic arst_n,
	bmd_req_if.sink   req,
	bmd_rsp_if.source rsp
);

	logic                           fire;
	logic                           can_accept;
	bmd_pkg::mem_cmd_t              cmd;
	bmd_pkg::rsp_ctl_t              ctl;
	logic [bmd_pkg::DATA_WIDTH-1:0] rdata;

	bmd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.can_accept (can_accept),
		.fire       (fire),
		.cmd        (cmd),
		.ctl        (ctl)
	);

	bmd_ram #(
		.DEPTH (bmd_pkg::STORE_DEPTH),
		.WIDTH (bmd_pkg::DATA_WIDTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.we),
		.re    (cmd.re),
		.addr  (cmd.addr),
		.wdata (cmd.wdata),
		.rdata (rdata)
	);

	bmd_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.ctl        (ctl),
		.rdata      (rdata),
		.can_accept (can_accept),
		.rsp        (rsp)
	);

endmodule

`default_nettype wire

// ===== rtl/bmd_ram.sv =====
// generic single-port synchronous ram with registered read
// no dependencies
`default_nettype none

module bmd_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]              rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/bmd_ctrl.sv =====
// position and count control: decodes a request, updates front, back and count,
// issues the store access; depends on bmd_pkg and bmd_req_if
`default_nettype none

module bmd_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	bmd_req_if.sink            req,
	input  wire logic          can_accept,
	output logic               fire,
	output bmd_pkg::mem_cmd_t  cmd,
	output bmd_pkg::rsp_ctl_t  ctl
);

	localparam int WIDE_W = bmd_pkg::POS_W + bmd_pkg::INDEX_W + 1;

	logic [bmd_pkg::POS_W-1:0] base_q, base_n;
	logic [bmd_pkg::OFF_W-1:0] off_q, off_n;
	logic [bmd_pkg::POS_W-1:0] last_q, last_n;
	logic [bmd_pkg::CNT_W-1:0] cnt_q, cnt_n;

	logic [bmd_pkg::POS_W-1:0] first;
	logic [bmd_pkg::POS_W-1:0] start_pos;
	logic                      empty;
	logic                      off_at_top;
	logic                      off_at_zero;
	logic [WIDE_W-1:0]         idx_wide;
	logic [WIDE_W-1:0]         cnt_wide;
	logic [WIDE_W-1:0]         pos_wide;
	bmd_pkg::status_t          status;
	logic                      we;
	logic                      re;
	logic [bmd_pkg::POS_W-1:0] addr;

	assign req.ready   = can_accept;
	assign fire        = req.valid && can_accept;

	assign first       = base_q + bmd_pkg::POS_W'(off_q);
	assign start_pos   = base_q + bmd_pkg::POS_W'(bmd_pkg::MID_OFF);
	assign empty       = (cnt_q == '0);
	assign off_at_top  = (off_q == bmd_pkg::OFF_W'(bmd_pkg::BLOCK_SIZE - 1));
	assign off_at_zero = (off_q == '0);
	assign idx_wide    = WIDE_W'(req.index);
	assign cnt_wide    = WIDE_W'(cnt_q);
	assign pos_wide    = WIDE_W'(first) + idx_wide;

	always_comb begin
		base_n = base_q;
		off_n  = off_q;
		last_n = last_q;
		cnt_n  = cnt_q;
		status = bmd_pkg::ST_OK;
		we     = 1'b0;
		re     = 1'b0;
		addr   = first;
		unique case (req.func)
			bmd_pkg::FN_PUSH_BACK: begin
				if (empty) begin
					off_n  = bmd_pkg::OFF_W'(bmd_pkg::MID_OFF);
					last_n = start_pos;
					cnt_n  = cnt_q + 1'b1;
					we     = 1'b1;
					addr   = start_pos;
				end else if (last_q == bmd_pkg::POS_W'(bmd_pkg::STORE_DEPTH - 1)) begin
					status = bmd_pkg::ST_FULL_BACK;
				end else begin
					last_n = last_q + 1'b1;
					cnt_n  = cnt_q + 1'b1;
					we     = 1'b1;
					addr   = last_q + 1'b1;
				end
			end
			bmd_pkg::FN_PUSH_FRONT: begin
				if (empty) begin
					off_n  = bmd_pkg::OFF_W'(bmd_pkg::MID_OFF);
					last_n = start_pos;
					cnt_n  = cnt_q + 1'b1;
					we     = 1'b1;
					addr   = start_pos;
				end else if (first == '0) begin
					status = bmd_pkg::ST_FULL_FRONT;
				end else begin
					if (off_at_zero) begin
						base_n = base_q - bmd_pkg::POS_W'(bmd_pkg::BLOCK_SIZE);
						off_n  = bmd_pkg::OFF_W'(bmd_pkg::BLOCK_SIZE - 1);
					end else begin
						off_n  = off_q - 1'b1;
					end
					cnt_n  = cnt_q + 1'b1;
					we     = 1'b1;
					addr   = first - 1'b1;
				end
			end
			bmd_pkg::FN_POP_BACK: begin
				if (empty) begin
					status = bmd_pkg::ST_EMPTY;
				end else begin
					if (cnt_q != bmd_pkg::CNT_W'(1)) begin
						last_n = last_q - 1'b1;
					end
					cnt_n = cnt_q - 1'b1;
				end
			end
			bmd_pkg::FN_POP_FRONT: begin
				if (empty) begin
					status = bmd_pkg::ST_EMPTY;
				end else begin
					if (cnt_q != bmd_pkg::CNT_W'(1)) begin
						if (off_at_top) begin
							base_n = base_q + bmd_pkg::POS_W'(bmd_pkg::BLOCK_SIZE);
							off_n  = '0;
						end else begin
							off_n  = off_q + 1'b1;
						end
					end
					cnt_n = cnt_q - 1'b1;
				end
			end
			bmd_pkg::FN_READ, bmd_pkg::FN_WRITE: begin
				if (idx_wide >= cnt_wide) begin
					status = bmd_pkg::ST_RANGE;
				end else begin
					addr = pos_wide[bmd_pkg::POS_W-1:0];
					re   = (req.func == bmd_pkg::FN_READ);
					we   = (req.func == bmd_pkg::FN_WRITE);
				end
			end
			default: begin
			end
		endcase
	end

	assign cmd.we      = fire && we;
	assign cmd.re      = fire && re;
	assign cmd.addr    = addr;
	assign cmd.wdata   = bmd_pkg::to_store(req.value);
	assign ctl.is_read = re;
	assign ctl.status  = status;
	assign ctl.count   = bmd_pkg::COUNT_W'(cnt_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= bmd_pkg::POS_W'(bmd_pkg::HOME_BASE);
			off_q  <= bmd_pkg::OFF_W'(bmd_pkg::MID_OFF);
			last_q <= bmd_pkg::POS_W'(bmd_pkg::HOME_POS);
			cnt_q  <= '0;
		end else if (fire) begin
			base_q <= base_n;
			off_q  <= off_n;
			last_q <= last_n;
			cnt_q  <= cnt_n;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/bmd_out.sv =====
// result path: holds a request while its store read completes, then an output
// register toward the result channel; depends on bmd_pkg and bmd_rsp_if
`default_nettype none

module bmd_out (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           fire,
	input  wire bmd_pkg::rsp_ctl_t              ctl,
	input  wire logic [bmd_pkg::DATA_WIDTH-1:0] rdata,
	output logic                                can_accept,
	bmd_rsp_if.source                           rsp
);

	logic              valid_s1;
	bmd_pkg::rsp_ctl_t ctl_s1;
	logic              valid_q;
	logic              advance;

	assign advance    = valid_s1 && (!valid_q || rsp.ready);
	assign can_accept = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (can_accept) begin
				valid_s1 <= fire;
			end
			if (advance) begin
				valid_q <= 1'b1;
			end else if (rsp.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// store read data holds until the next read is issued, so it is taken here
	always_ff @(posedge clk) begin
		if (fire && can_accept) begin
			ctl_s1 <= ctl;
		end
		if (advance) begin
			rsp.read_data <= ctl_s1.is_read ? bmd_pkg::from_store(rdata) : '0;
			rsp.status    <= ctl_s1.status;
			rsp.count     <= ctl_s1.count;
		end
	end

	assign rsp.valid = valid_q;

endmodule

`default_nettype wire

// ===== rtl/bmd_checker.sv =====
// port-level checks on the block map deque result channel, bound to the top level
// depends on bmd_pkg and block_map_deque_assert.svh
`default_nettype none

`include "block_map_deque_assert.svh"

module bmd_checker (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               out_valid,
	input wire logic                               out_ready,
	input wire logic [bmd_pkg::READ_W-1:0]         out_read_data,
	input wire logic [bmd_pkg::STATUS_W-1:0]       out_status,
	input wire logic [bmd_pkg::COUNT_W-1:0]        out_count
);

	// a stalled result holds
	`BMD_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_read_data) && $stable(out_status) && $stable(out_count), "result changed while stalled")

	// only a good read returns data
	`BMD_ASSERT_IMP(a_err_zero, out_valid && (out_status != bmd_pkg::ST_OK), out_read_data == '0, "failed request returned data")

	// empty status only with no elements
	`BMD_ASSERT_IMP(a_empty_cnt, out_valid && (out_status == bmd_pkg::ST_EMPTY), out_count == '0, "empty status with elements held")

	// a full end means the deque holds something
	`BMD_ASSERT_IMP(a_full_cnt, out_valid && ((out_status == bmd_pkg::ST_FULL_BACK) || (out_status == bmd_pkg::ST_FULL_FRONT)), out_count != '0, "full status on empty deque")

endmodule

bind block_map_deque bmd_checker u_bmd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (rsp.valid),
	.out_ready     (rsp.ready),
	.out_read_data (rsp.read_data),
	.out_status    (rsp.status),
	.out_count     (rsp.count)
);

`default_nettype wire

// ===== dv/deque_checker.sv =====
// request/result monitor for the block map deque: models the deque state,
// predicts each result and compares it with what the block returns
// depends on bmd_pkg, bmd_req_if and bmd_rsp_if
`default_nettype none

module deque_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	bmd_req_if        req,
	bmd_rsp_if        rsp,
	output int        errors,
	output int        waiting
);

	localparam int REPORT_LIMIT = 10;
	localparam int PEND_DEPTH   = 64;

	typedef struct packed {
		logic [bmd_pkg::READ_W-1:0]  read_data;
		bmd_pkg::status_t            status;
		logic [bmd_pkg::COUNT_W-1:0] count;
	} deque_outcome_t;

	logic [bmd_pkg::DATA_WIDTH-1:0] slot_mem [bmd_pkg::STORE_DEPTH];
	int                             front_pos;
	int                             back_pos;
	int                             elem_cnt;
	int                             fail_cnt = 0;
	deque_outcome_t                 pend_buf [PEND_DEPTH];
	int                             pend_wr = 0;
	int                             pend_rd = 0;
	int                             pend_cnt = 0;

	// empty deque restarts in the middle of its current block
	function automatic void recentre();
		front_pos = (front_pos / bmd_pkg::BLOCK_SIZE) * bmd_pkg::BLOCK_SIZE
			+ bmd_pkg::BLOCK_SIZE / 2;
		back_pos  = front_pos;
	endfunction

	function automatic deque_outcome_t apply_request(
		input logic [bmd_pkg::FUNC_W-1:0]         f,
		input logic signed [bmd_pkg::VALUE_W-1:0] v,
		input logic [bmd_pkg::INDEX_W-1:0]        i
	);
		deque_outcome_t o;
		int             slot;
		o = '0;
		case (f)
			bmd_pkg::FN_PUSH_BACK: begin
				if (elem_cnt == 0)
					recentre();
				else if (back_pos >= bmd_pkg::STORE_DEPTH - 1)
					o.status = bmd_pkg::ST_FULL_BACK;
				else
					back_pos++;
				if (o.status == bmd_pkg::ST_OK) begin
					slot_mem[back_pos] = bmd_pkg::DATA_WIDTH'(v);
					elem_cnt++;
				end
			end
			bmd_pkg::FN_PUSH_FRONT: begin
				if (elem_cnt == 0)
					recentre();
				else if (front_pos == 0)
					o.status = bmd_pkg::ST_FULL_FRONT;
				else
					front_pos--;
				if (o.status == bmd_pkg::ST_OK) begin
					slot_mem[front_pos] = bmd_pkg::DATA_WIDTH'(v);
					elem_cnt++;
				end
			end
			bmd_pkg::FN_POP_BACK: begin
				if (elem_cnt == 0) begin
					o.status = bmd_pkg::ST_EMPTY;
				end else begin
					if (elem_cnt > 1)
						back_pos--;
					elem_cnt--;
				end
			end
			bmd_pkg::FN_POP_FRONT: begin
				if (elem_cnt == 0) begin
					o.status = bmd_pkg::ST_EMPTY;
				end else begin
					if (elem_cnt > 1)
						front_pos++;
					elem_cnt--;
				end
			end
			bmd_pkg::FN_READ, bmd_pkg::FN_WRITE: begin
				if (int'(i) >= elem_cnt) begin
					o.status = bmd_pkg::ST_RANGE;
				end else begin
					slot = front_pos + int'(i);
					if (f == bmd_pkg::FN_READ)
						o.read_data = bmd_pkg::READ_W'(signed'(slot_mem[slot]));
					else
						slot_mem[slot] = bmd_pkg::DATA_WIDTH'(v);
				end
			end
			default: begin
			end
		endcase
		o.count = bmd_pkg::COUNT_W'(elem_cnt);
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		deque_outcome_t got;
		deque_outcome_t want;
		if (!arst_n) begin
			front_pos = bmd_pkg::HOME_POS;
			back_pos  = bmd_pkg::HOME_POS;
			elem_cnt  = 0;
			pend_wr   = 0;
			pend_rd   = 0;
			pend_cnt  = 0;
		end else begin
			if (req.valid && req.ready) begin
				if (pend_cnt >= PEND_DEPTH) begin
					fail_cnt++;
				end else begin
					pend_buf[pend_wr] = apply_request(req.func, req.value, req.index);
					pend_wr = (pend_wr + 1) % PEND_DEPTH;
					pend_cnt++;
				end
			end
			if (rsp.valid && rsp.ready) begin
				got.read_data = rsp.read_data;
				got.status    = bmd_pkg::status_t'(rsp.status);
				got.count     = rsp.count;
				if (pend_cnt == 0) begin
					if (fail_cnt < REPORT_LIMIT)
						$display("unexpected result: read_data %0d status %0d count %0d",
							$signed(got.read_data), got.status, got.count);
					fail_cnt++;
				end else begin
					want = pend_buf[pend_rd];
					pend_rd = (pend_rd + 1) % PEND_DEPTH;
					pend_cnt--;
					if (got.read_data !== want.read_data || got.status !== want.status ||
						got.count !== want.count) begin
						if (fail_cnt < REPORT_LIMIT)
							$display({"mismatch: expected read_data %0d status %0d count %0d,",
								" got read_data %0d status %0d count %0d"},
								$signed(want.read_data), want.status, want.count,
								$signed(got.read_data), got.status, got.count);
						fail_cnt++;
					end
				end
			end
		end
		errors  <= fail_cnt;
		waiting <= pend_cnt;
	end

endmodule

`default_nettype wire

// ===== dv/tb_block_map_deque.sv =====
// top of the block map deque testbench: clock, reset, request stimulus and
// result back-pressure, with the verdict taken from deque_checker
// depends on bmd_pkg, bmd_req_if, bmd_rsp_if, block_map_deque and deque_checker
`default_nettype none

module tb_block_map_deque;

	localparam int CLK_HALF     = 4;
	localparam int RESET_CYCLES = 4;
	localparam int RANDOM_ITEMS = 730;
	localparam int SEGMENT      = 90;
	localparam int QUIET_TAIL   = 150;
	localparam int HOLD_AT      = 200;
	localparam int LONG_HOLD    = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam int LIMIT_CYCLES = 400000;

	localparam logic [bmd_pkg::FUNC_W-1:0] FN_SPARE_LO = 3'd6;
	localparam logic [bmd_pkg::FUNC_W-1:0] FN_SPARE_HI = 3'd7;

	typedef enum int {
		MODE_FILL,
		MODE_GROW_BACK,
		MODE_GROW_FRONT,
		MODE_DRAIN,
		MODE_MIXED
	} mix_mode_t;

	logic clk = 1'b0;
	logic arst_n;
	bit   idle_on  = 1'b1;
	bit   hold_req = 1'b0;
	int   errors;
	int   waiting;

	bmd_req_if req_ch ();
	bmd_rsp_if rsp_ch ();

	block_map_deque dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	deque_checker deque_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.errors  (errors),
		.waiting (waiting)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	task automatic send_request(
		input logic [bmd_pkg::FUNC_W-1:0]         f,
		input logic signed [bmd_pkg::VALUE_W-1:0] v,
		input logic [bmd_pkg::INDEX_W-1:0]        i
	);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.func  <= f;
		req_ch.value <= v;
		req_ch.index <= i;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	function automatic logic [bmd_pkg::FUNC_W-1:0] pick_func(input mix_mode_t m);
		int r;
		r = $urandom_range(0, 99);
		case (m)
			MODE_FILL: begin
				if (r < 45) return bmd_pkg::FN_PUSH_BACK;
				if (r < 90) return bmd_pkg::FN_PUSH_FRONT;
				if (r < 95) return bmd_pkg::FN_READ;
				return bmd_pkg::FN_WRITE;
			end
			MODE_GROW_BACK: begin
				if (r < 70) return bmd_pkg::FN_PUSH_BACK;
				if (r < 76) return bmd_pkg::FN_POP_BACK;
				if (r < 82) return bmd_pkg::FN_POP_FRONT;
				if (r < 91) return bmd_pkg::FN_READ;
				return bmd_pkg::FN_WRITE;
			end
			MODE_GROW_FRONT: begin
				if (r < 70) return bmd_pkg::FN_PUSH_FRONT;
				if (r < 76) return bmd_pkg::FN_POP_FRONT;
				if (r < 82) return bmd_pkg::FN_POP_BACK;
				if (r < 91) return bmd_pkg::FN_READ;
				return bmd_pkg::FN_WRITE;
			end
			MODE_DRAIN: begin
				if (r < 35) return bmd_pkg::FN_POP_BACK;
				if (r < 70) return bmd_pkg::FN_POP_FRONT;
				if (r < 80) return bmd_pkg::FN_PUSH_BACK;
				if (r < 90) return bmd_pkg::FN_PUSH_FRONT;
				return bmd_pkg::FN_READ;
			end
			default: return bmd_pkg::FUNC_W'($urandom_range(0, 7));
		endcase
	endfunction

	function automatic logic signed [bmd_pkg::VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'sh7fff_ffff;
			1: return 32'sh8000_0000;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [bmd_pkg::INDEX_W-1:0] pick_index();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7) return bmd_pkg::INDEX_W'($urandom_range(0, 7));
		if (r < 9) return bmd_pkg::INDEX_W'($urandom_range(0, 31));
		return bmd_pkg::INDEX_W'($urandom_range(0, 63));
	endfunction

	// result side: short random stalls, one long hold-off on request
	initial begin
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			repeat ($urandom_range(0, 10)) @(posedge clk);
		end
	end

	initial begin
		mix_mode_t mode;
		mode = MODE_FILL;
		req_ch.valid <= 1'b0;
		req_ch.func  <= bmd_pkg::FN_PUSH_BACK;
		req_ch.value <= '0;
		req_ch.index <= '0;
		arst_n       <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty deque: pops, index access and spare codes
		send_request(bmd_pkg::FN_POP_BACK, '0, '0);
		send_request(bmd_pkg::FN_POP_FRONT, '0, '0);
		send_request(bmd_pkg::FN_READ, '0, '0);
		send_request(bmd_pkg::FN_WRITE, 32'sh0000_1234, '0);
		send_request(FN_SPARE_LO, '1, '1);
		send_request(FN_SPARE_HI, '1, '1);
		// pushes at both ends with extreme values
		send_request(bmd_pkg::FN_PUSH_BACK, 32'sh7fff_ffff, '0);
		send_request(bmd_pkg::FN_PUSH_FRONT, 32'sh8000_0000, '1);
		send_request(bmd_pkg::FN_PUSH_BACK, '1, '0);
		send_request(bmd_pkg::FN_PUSH_FRONT, '0, '0);
		for (int k = 0; k < 4; k++)
			send_request(bmd_pkg::FN_READ, '0, bmd_pkg::INDEX_W'(k));
		send_request(bmd_pkg::FN_WRITE, 32'sh5a5a_a5a5, 6'd2);
		send_request(bmd_pkg::FN_READ, '0, 6'd2);
		send_request(bmd_pkg::FN_READ, '0, 6'd4);
		send_request(bmd_pkg::FN_WRITE, 32'sh0000_0001, '1);
		// drain to empty, positions kept
		send_request(bmd_pkg::FN_POP_BACK, '0, '0);
		send_request(bmd_pkg::FN_POP_FRONT, '0, '0);
		send_request(bmd_pkg::FN_POP_BACK, '0, '0);
		send_request(bmd_pkg::FN_POP_FRONT, '0, '0);
		send_request(bmd_pkg::FN_POP_BACK, '0, '0);
		send_request(bmd_pkg::FN_PUSH_FRONT, 32'sh0000_002a, '0);
		send_request(bmd_pkg::FN_READ, '0, '0);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % SEGMENT == 0) begin
				if (n != 0)
					mode = mix_mode_t'($urandom_range(0, 4));
				idle_on = (n < RANDOM_ITEMS - QUIET_TAIL) && ($urandom_range(0, 2) != 0);
			end
			if (n >= RANDOM_ITEMS - QUIET_TAIL)
				idle_on = 1'b0;
			if (n == HOLD_AT)
				hold_req = 1'b1;
			send_request(pick_func(mode), pick_value(), pick_index());
		end
		req_ch.valid <= 1'b0;

		@(posedge clk);
		while (waiting != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && waiting == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#(LIMIT_CYCLES * 2 * CLK_HALF);
		$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire
